### src/shp_pkg.sv
// shared types, codes and helpers for the stepper homing / positioning core
// no dependencies; used by every module of the block
package shp_pkg;

    localparam int STEPS_PER_REV_DEF = 48;
    localparam int POS_W    = 6;
    localparam int OP_W     = 2;
    localparam int STEP_W   = 2;
    localparam int MODE_W   = 2;
    localparam int TGT_SPAN = 1 << POS_W;

    localparam logic [POS_W-1:0] OFFSET_RESET = 6'd12;

    // reported mode codes
    localparam logic [MODE_W-1:0] MODE_SEEK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OFFSET = 2'd1;
    localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MOVE   = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_CAL  = 2'd1,
        OP_GOTO = 2'd2
    } op_t;

    typedef enum logic [STEP_W-1:0] {
        STEP_NONE  = 2'd0,
        STEP_LEFT  = 2'd1,
        STEP_RIGHT = 2'd2
    } step_t;

    typedef enum logic [3:0] {
        ST_SEEK   = 4'b0001,
        ST_OFFSET = 4'b0010,
        ST_IDLE   = 4'b0100,
        ST_MOVE   = 4'b1000
    } mode_state_t;

    typedef struct packed {
        mode_state_t st;
        step_t       step;
    } shp_ctl_t;

    function automatic logic [MODE_W-1:0] mode_code(input mode_state_t st);
        logic [MODE_W-1:0] code;
        unique case (st)
            ST_SEEK:   code = MODE_SEEK;
            ST_OFFSET: code = MODE_OFFSET;
            ST_IDLE:   code = MODE_IDLE;
            ST_MOVE:   code = MODE_MOVE;
            default:   code = MODE_SEEK;
        endcase
        return code;
    endfunction

    // elaboration-time remainder by repeated subtraction, feeds a constant table
    function automatic int mod_n(input int v, input int n);
        int r;
        r = v;
        for (int i = 0; i < TGT_SPAN; i++) begin
            if (r >= n) begin
                r = r - n;
            end
        end
        return r;
    endfunction

endpackage

### src/shp_step_logic.sv
// next-state and step decision for one item, purely combinational
// depends on shp_pkg
module shp_step_logic #(
    parameter int STEPS_PER_REV = shp_pkg::STEPS_PER_REV_DEF,
    parameter int PW            = $clog2(STEPS_PER_REV)
) (
    input  logic [shp_pkg::OP_W-1:0]  op,
    input  logic [shp_pkg::POS_W-1:0] tgt_in,
    input  logic                      det,
    input  logic [shp_pkg::POS_W-1:0] offset_steps,
    input  shp_pkg::mode_state_t      st,
    input  logic [PW-1:0]             cur,
    input  logic [PW-1:0]             tgt,
    output shp_pkg::shp_ctl_t         ctl_next,
    output logic [PW-1:0]             cur_next,
    output logic [PW-1:0]             tgt_next
);

    localparam int CW = (PW > shp_pkg::POS_W) ? PW : shp_pkg::POS_W;

    logic [PW-1:0] tgt_tab [shp_pkg::TGT_SPAN];
    logic [CW-1:0] off_w;
    logic [CW-1:0] off_clamp;
    logic [CW-1:0] cur_w;
    logic [PW:0]   diff;
    logic [PW-1:0] cur_inc;
    logic [PW-1:0] cur_dec;

    // target reduced modulo the circle size, as a constant table
    for (genvar g = 0; g < shp_pkg::TGT_SPAN; g++) begin : g_tgt_tab
        assign tgt_tab[g] = PW'(shp_pkg::mod_n(g, STEPS_PER_REV));
    end

    assign off_w     = CW'(offset_steps);
    assign off_clamp = (off_w >= CW'(STEPS_PER_REV - 1)) ? CW'(STEPS_PER_REV - 1) : off_w;
    assign cur_w     = CW'(cur);

    // distance going right, modulo the circle
    assign diff = (tgt >= cur) ? ({1'b0, tgt} - {1'b0, cur})
                               : ({1'b0, tgt} + (PW+1)'(STEPS_PER_REV) - {1'b0, cur});

    assign cur_inc = (cur == PW'(STEPS_PER_REV - 1)) ? '0 : cur + PW'(1);
    assign cur_dec = (cur == '0) ? PW'(STEPS_PER_REV - 1) : cur - PW'(1);

    always_comb begin
        ctl_next.st   = st;
        ctl_next.step = shp_pkg::STEP_NONE;
        cur_next      = cur;
        tgt_next      = tgt;
        case (op)
            shp_pkg::OP_TICK: begin
                unique case (st)
                    shp_pkg::ST_SEEK: begin
                        if (det) begin
                            cur_next    = '0;
                            ctl_next.st = shp_pkg::ST_OFFSET;
                        end else begin
                            ctl_next.step = shp_pkg::STEP_LEFT;
                        end
                    end
                    shp_pkg::ST_OFFSET: begin
                        if (cur_w >= off_clamp) begin
                            cur_next    = '0;
                            tgt_next    = '0;
                            ctl_next.st = shp_pkg::ST_IDLE;
                        end else begin
                            ctl_next.step = shp_pkg::STEP_RIGHT;
                            cur_next      = cur_inc;
                        end
                    end
                    shp_pkg::ST_IDLE: begin
                        if (cur != tgt) begin
                            ctl_next.st = shp_pkg::ST_MOVE;
                        end
                    end
                    shp_pkg::ST_MOVE: begin
                        if (cur == tgt) begin
                            ctl_next.st = shp_pkg::ST_IDLE;
                        end else if (diff <= (PW+1)'(STEPS_PER_REV / 2)) begin
                            ctl_next.step = shp_pkg::STEP_RIGHT;
                            cur_next      = cur_inc;
                        end else begin
                            ctl_next.step = shp_pkg::STEP_LEFT;
                            cur_next      = cur_dec;
                        end
                    end
                    default: begin
                        ctl_next.st = shp_pkg::ST_SEEK;
                    end
                endcase
            end
            shp_pkg::OP_CAL: begin
                ctl_next.st = shp_pkg::ST_SEEK;
            end
            shp_pkg::OP_GOTO: begin
                tgt_next    = tgt_tab[tgt_in];
                ctl_next.st = shp_pkg::ST_MOVE;
            end
            default: begin
                // unused opcode leaves everything alone
            end
        endcase
    end

endmodule

### src/stepper_homing_positioner_core.sv
// an input transfer reaches m_valid through the input register, then the result
// register; throughput one item per cycle while m_ready is high, set by the
// single pass through the step logic and its state registers.
// reset (aresetn low, synchronous): seeking home, position and target zero,
// offset_steps 12, both channels empty
// top level of the stepper homing / positioning core; depends on shp_pkg, shp_step_logic
module stepper_homing_positioner_core #(
    parameter int STEPS_PER_REV = shp_pkg::STEPS_PER_REV_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [shp_pkg::POS_W-1:0]   cfg_offset_steps,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [shp_pkg::OP_W-1:0]    s_opcode,
    input  logic [shp_pkg::POS_W-1:0]   s_target_position,
    input  logic                        s_detector_active,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [shp_pkg::STEP_W-1:0]  m_step_command,
    output logic [shp_pkg::MODE_W-1:0]  m_mode,
    output logic [shp_pkg::POS_W-1:0]   m_position,
    output logic                        m_busy_res
);

    localparam int PW = $clog2(STEPS_PER_REV);

    logic                        in_valid_reg;
    logic [shp_pkg::OP_W-1:0]    op_reg;
    logic [shp_pkg::POS_W-1:0]   tgt_in_reg;
    logic                        det_reg;
    logic [shp_pkg::POS_W-1:0]   offset_reg;
    shp_pkg::mode_state_t        st_reg;
    logic [PW-1:0]               cur_reg;
    logic [PW-1:0]               tgt_reg;
    logic                        out_valid_reg;
    logic [shp_pkg::STEP_W-1:0]  step_reg;
    logic [shp_pkg::MODE_W-1:0]  mode_reg;
    logic [shp_pkg::POS_W-1:0]   pos_reg;
    logic                        busy_reg;

    shp_pkg::shp_ctl_t ctl_next;
    logic [PW-1:0]     cur_next;
    logic [PW-1:0]     tgt_next;
    logic              advance;

    // the held item moves on when the result register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    shp_step_logic #(
        .STEPS_PER_REV(STEPS_PER_REV),
        .PW           (PW)
    ) u_step (
        .op          (op_reg),
        .tgt_in      (tgt_in_reg),
        .det         (det_reg),
        .offset_steps(offset_reg),
        .st          (st_reg),
        .cur         (cur_reg),
        .tgt         (tgt_reg),
        .ctl_next    (ctl_next),
        .cur_next    (cur_next),
        .tgt_next    (tgt_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            offset_reg    <= shp_pkg::OFFSET_RESET;
            st_reg        <= shp_pkg::ST_SEEK;
            cur_reg       <= '0;
            tgt_reg       <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                offset_reg <= cfg_offset_steps;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                st_reg        <= ctl_next.st;
                cur_reg       <= cur_next;
                tgt_reg       <= tgt_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg     <= s_opcode;
            tgt_in_reg <= s_target_position;
            det_reg    <= s_detector_active;
        end
        if (advance) begin
            step_reg <= ctl_next.step;
            mode_reg <= shp_pkg::mode_code(ctl_next.st);
            pos_reg  <= shp_pkg::POS_W'(cur_next);
            busy_reg <= (ctl_next.st != shp_pkg::ST_IDLE);
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_step_command = step_reg;
    assign m_mode         = mode_reg;
    assign m_position     = pos_reg;
    assign m_busy_res     = busy_reg;

endmodule

### src/shp_checker.sv
// port-level checks for the stepper homing / positioning core, bound to the top
// depends on shp_pkg and stepper_homing_positioner_core
module shp_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [shp_pkg::STEP_W-1:0]  m_step_command,
    input logic [shp_pkg::MODE_W-1:0]  m_mode,
    input logic [shp_pkg::POS_W-1:0]   m_position,
    input logic                        m_busy_res
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position) && $stable(m_mode)
                                && $stable(m_step_command))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_busy_res == (m_mode != shp_pkg::MODE_IDLE)))
        else $error("busy flag does not match mode");

    // reaching or staying idle never moves the motor
    a_idle_still: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mode == shp_pkg::MODE_IDLE |-> m_step_command == shp_pkg::STEP_NONE)
        else $error("step issued in idle");

    // homing only steps left, offsetting only steps right
    a_calib_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_mode == shp_pkg::MODE_SEEK && m_step_command == shp_pkg::STEP_RIGHT)
                    && !(m_mode == shp_pkg::MODE_OFFSET
                         && m_step_command == shp_pkg::STEP_LEFT))
        else $error("wrong step direction during calibration");

endmodule

bind stepper_homing_positioner_core shp_checker u_shp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_step_command(m_step_command),
    .m_mode        (m_mode),
    .m_position    (m_position),
    .m_busy_res    (m_busy_res)
);
